### rtl/sprp_pkg.sv
// sprp_pkg: shared constants and types for the sphere point rotate/project block.
// Used by sphere_point_rotate_project; no dependencies.

package sprp_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int TRIG_FRAC_DEF  = 15;
  localparam int COORD_BITS_DEF = 12;

  // Quarter-wave sine polynomial runs at this many fraction bits.
  localparam int WORK_BITS = 30;
  localparam int POLY_W    = WORK_BITS + 1;

  // Odd Taylor coefficients, highest power first, Horner order.
  localparam logic [POLY_W-1:0] POLY_COEF [5] = '{
    31'd172272, 31'd5026995, 31'd85569305, 31'd693598669, 31'd1686629713
  };

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROLL   = 3'd0,
    REG_PITCH  = 3'd1,
    REG_YAW    = 3'd2,
    REG_RADIUS = 3'd3,
    REG_CX     = 3'd4,
    REG_CY     = 3'd5,
    REG_YSCALE = 3'd6
  } cfg_reg_e;

  localparam int ROLL_RST   = 10923;
  localparam int PITCH_RST  = 5461;
  localparam int YAW_RST    = 2332;
  localparam int RADIUS_RST = 190;
  localparam int CX_RST     = 300;
  localparam int CY_RST     = 165;
  localparam int YSCALE_RST = 205;

endpackage

### rtl/sphere_point_rotate_project.sv
// sphere_point_rotate_project: top level, sequencer and datapath around one multiplier.
// Depends on sprp_pkg and sprp_mul.

// Takes points on a sphere (polar and azimuth binary angles), rotates them by a matrix
// built from the roll, pitch and yaw registers, drops points whose depth is not positive
// and projects the rest orthographically (y squashed by y_scale/256) around the screen
// centre. From the second visible point of a curve on, each point yields one segment
// item (previous point to this point). All products come from a single registered
// signed multiplier; every product has an issue step and a write-back step. One item
// passes through four sine/cosine evaluations of six products each, fifteen point
// products and one emit step; a hidden point stops after the depth product. After reset
// and after every angle register write the matrix is rebuilt: six trig evaluations and
// fourteen products, with no item accepted meanwhile. The result sits in an output
// register, so a new item is taken while a segment still waits downstream.
// Configuration writes are taken only while the block is idle (no item in flight and
// no matrix build running); an angle write starts a new build.

module sphere_point_rotate_project #(
  parameter int ANGLE_BITS         = sprp_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_FRACTION_BITS = sprp_pkg::TRIG_FRAC_DEF,
  parameter int COORD_BITS         = sprp_pkg::COORD_BITS_DEF,
  localparam int InW  = ((2*ANGLE_BITS + 7) / 8) * 8,
  localparam int OutW = ((4*COORD_BITS + 7) / 8) * 8,
  localparam int CfgW = (ANGLE_BITS > 10) ? ANGLE_BITS : 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // fields from bit 0: polar_angle, azimuth_angle
  input  logic [InW-1:0]                   s_axis_tdata,
  // fields: new_curve
  input  logic                             s_axis_tuser,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // fields from bit 0: from_x, from_y, to_x, to_y
  output logic [OutW-1:0]                  m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sprp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CfgW-1:0]                  cfg_data_i
);

  localparam int A   = ANGLE_BITS;
  localparam int F   = TRIG_FRACTION_BITS;
  localparam int C   = COORD_BITS;
  localparam int QB  = A - 2;
  localparam int WB  = sprp_pkg::WORK_BITS;
  localparam int PLW = sprp_pkg::POLY_W;
  localparam int TW  = F + 2;            // trig value, signed
  localparam int MW  = F + 3;            // matrix entry, signed
  localparam int FW  = F + 11;           // radius times trig product
  localparam int AW  = FW + MW + 2;      // rotation sum
  localparam int YW  = AW - F;           // rotated coordinate
  localparam int OW  = (YW > 33) ? YW : 33;
  localparam int PW  = 2 * OW;
  localparam int RND = 1 << (WB - F - 1);
  localparam int FMASK  = (1 << F) - 1;
  localparam int YSH    = F + 8;
  localparam int YMASK  = (1 << YSH) - 1;
  localparam int CMAX   = (1 << (C - 1)) - 1;
  localparam int CMIN   = -(1 << (C - 1));
  localparam logic [2:0] TRIG_LAST = 3'd5;
  localparam logic [3:0] MAT_LAST  = 4'd13;
  localparam logic [3:0] PNT_DEPTH = 4'd7;
  localparam logic [3:0] PNT_LAST  = 4'd14;

  typedef enum logic [2:0] {
    ST_IDLE, ST_TRIG, ST_MAT, ST_PNT, ST_EMIT
  } state_e;

  state_e state_q;
  logic   mode_pnt_q, ph_q;
  logic [2:0] j_q, tstep_q;
  logic [3:0] op_q;

  logic [A-1:0] roll_q, pitch_q, yaw_q, polar_q, azim_q;
  logic [8:0]   rad_q, ysc_q;
  logic [9:0]   cx_q, cy_q;

  logic                have_prev_q, out_valid_q;
  logic signed [C-1:0] prev_x_q, prev_y_q;
  logic signed [C-1:0] from_x_q, from_y_q, to_x_q, to_y_q;

  // datapath registers
  logic [PLW-1:0]        z2_q, p_q;
  logic signed [TW-1:0]  tv_q [6];
  logic signed [TW-1:0]  ta_q, tb_q, g0_q, g1_q;
  logic signed [MW-1:0]  m_q [9];
  logic signed [FW-1:0]  f0_q, f1_q, f2_q;
  logic signed [AW-1:0]  acc_q;
  logic signed [YW-1:0]  xs_q, ys_q;
  logic signed [C-1:0]   px_q, py_q;

  logic in_fire, cfg_fire, out_fire;
  assign cfg_ready_o   = (state_q == ST_IDLE);
  assign cfg_fire      = cfg_valid_i && cfg_ready_o;
  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid_i;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign out_fire      = out_valid_q && m_axis_tready;
  assign m_axis_tdata  = OutW'({to_y_q, to_x_q, from_y_q, from_x_q});

  // ---- trig argument: fold the angle into a quarter wave ----
  logic [A-1:0]   ang_base, ang;
  logic [QB:0]    arg;
  logic [PLW-1:0] zval;
  logic           tneg;

  always_comb begin
    if (mode_pnt_q) begin
      ang_base = j_q[1] ? azim_q : polar_q;
    end else begin
      unique case (j_q[2:1])
        2'd0:    ang_base = roll_q;
        2'd1:    ang_base = pitch_q;
        default: ang_base = yaw_q;
      endcase
    end
    ang  = ang_base + (j_q[0] ? (A'(1) << QB) : '0);
    arg  = ang[A-2] ? (((QB+1)'(1) << QB) - {1'b0, ang[QB-1:0]}) : {1'b0, ang[QB-1:0]};
    zval = {arg, {(WB-QB){1'b0}}};
    tneg = ang[A-1];
  end

  // ---- multiplier operands ----
  logic signed [OW-1:0] opa, opb;
  logic signed [TW-1:0] mta, mtb;
  logic signed [PW-1:0] prod_w;
  logic                 mul_en;

  always_comb begin
    unique case (op_q)
      4'd0:    begin mta = tv_q[0]; mtb = tv_q[2]; end
      4'd1:    begin mta = tv_q[1]; mtb = tv_q[2]; end
      4'd2:    begin mta = tv_q[3]; mtb = tv_q[5]; end
      4'd3:    begin mta = tv_q[3]; mtb = tv_q[4]; end
      4'd4:    begin mta = ta_q;    mtb = tv_q[5]; end
      4'd5:    begin mta = tv_q[1]; mtb = tv_q[4]; end
      4'd6:    begin mta = ta_q;    mtb = tv_q[4]; end
      4'd7:    begin mta = tv_q[1]; mtb = tv_q[5]; end
      4'd8:    begin mta = tv_q[0]; mtb = tv_q[3]; end
      4'd9:    begin mta = tb_q;    mtb = tv_q[5]; end
      4'd10:   begin mta = tv_q[0]; mtb = tv_q[4]; end
      4'd11:   begin mta = tb_q;    mtb = tv_q[4]; end
      4'd12:   begin mta = tv_q[0]; mtb = tv_q[5]; end
      default: begin mta = tv_q[1]; mtb = tv_q[3]; end
    endcase

    opa = '0;
    opb = '0;
    unique case (state_q)
      ST_TRIG: begin
        if (tstep_q == 3'd0) begin
          opa = OW'(zval);
          opb = OW'(zval);
        end else if (tstep_q == TRIG_LAST) begin
          opa = OW'(zval);
          opb = OW'(p_q);
        end else begin
          opa = OW'(z2_q);
          opb = OW'(p_q);
        end
      end
      ST_MAT: begin
        opa = OW'(mta);
        opb = OW'(mtb);
      end
      ST_PNT: begin
        unique case (op_q)
          4'd0:    begin opa = OW'(tv_q[0]); opb = OW'(tv_q[3]); end
          4'd1:    begin opa = OW'(tv_q[0]); opb = OW'(tv_q[2]); end
          4'd2:    begin opa = OW'(rad_q);   opb = OW'(g0_q);    end
          4'd3:    begin opa = OW'(rad_q);   opb = OW'(g1_q);    end
          4'd4:    begin opa = OW'(rad_q);   opb = OW'(tv_q[1]); end
          4'd5:    begin opa = OW'(f0_q);    opb = OW'(m_q[2]);  end
          4'd6:    begin opa = OW'(f1_q);    opb = OW'(m_q[5]);  end
          4'd7:    begin opa = OW'(f2_q);    opb = OW'(m_q[8]);  end
          4'd8:    begin opa = OW'(f0_q);    opb = OW'(m_q[0]);  end
          4'd9:    begin opa = OW'(f1_q);    opb = OW'(m_q[3]);  end
          4'd10:   begin opa = OW'(f2_q);    opb = OW'(m_q[6]);  end
          4'd11:   begin opa = OW'(f0_q);    opb = OW'(m_q[1]);  end
          4'd12:   begin opa = OW'(f1_q);    opb = OW'(m_q[4]);  end
          4'd13:   begin opa = OW'(f2_q);    opb = OW'(m_q[7]);  end
          default: begin opa = OW'(ys_q);    opb = OW'(ysc_q);   end
        endcase
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign mul_en = !ph_q && ((state_q == ST_TRIG) || (state_q == ST_MAT) ||
                            (state_q == ST_PNT));

  sprp_mul #(.OpWidth(OW)) u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (opa),
    .b_i   (opb),
    .p_o   (prod_w)
  );

  // ---- write-back arithmetic ----
  logic [PLW:0]          pf;
  logic [PLW-1:0]        pc, pr;
  logic signed [TW-1:0]  tmag, tval;
  logic signed [MW-1:0]  mf;
  logic signed [AW-1:0]  sum, dep;
  logic                  visible;
  logic signed [YW:0]    vx, tx;
  logic signed [PW:0]    vy, ty;
  logic signed [C-1:0]   px_c, py_c;

  always_comb begin
    pf   = prod_w[2*WB+1:WB];
    pc   = (pf > (PLW+1)'(1 << WB)) ? PLW'(1 << WB) : pf[PLW-1:0];
    pr   = pc + PLW'(RND);
    tmag = $signed({1'b0, pr[PLW-1:WB-F]});
    tval = tneg ? -tmag : tmag;

    mf      = MW'(prod_w >>> F);
    sum     = acc_q + AW'(prod_w);
    dep     = sum >>> F;
    visible = !dep[AW-1] && (dep != '0);

    // truncate toward zero, then saturate
    vx = (YW+1)'(xs_q) + $signed((YW+1)'(cx_q) << F);
    tx = vx[YW] ? ((vx + $signed((YW+1)'(FMASK))) >>> F) : (vx >>> F);
    if (tx > (YW+1)'(CMAX))       px_c = C'(CMAX);
    else if (tx < (YW+1)'(CMIN))  px_c = C'(CMIN);
    else                          px_c = C'(tx);

    vy = (PW+1)'(prod_w) + $signed((PW+1)'(cy_q) << YSH);
    ty = vy[PW] ? ((vy + $signed((PW+1)'(YMASK))) >>> YSH) : (vy >>> YSH);
    if (ty > (PW+1)'(CMAX))       py_c = C'(CMAX);
    else if (ty < (PW+1)'(CMIN))  py_c = C'(CMIN);
    else                          py_c = C'(ty);
  end

  // ---- datapath registers ----
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      polar_q <= s_axis_tdata[A-1:0];
      azim_q  <= s_axis_tdata[2*A-1:A];
    end
    if (ph_q) begin
      unique case (state_q)
        ST_TRIG: begin
          if (tstep_q == 3'd0) begin
            z2_q <= prod_w[2*WB:WB];
            p_q  <= sprp_pkg::POLY_COEF[0];
          end else if (tstep_q == TRIG_LAST) begin
            tv_q[j_q] <= tval;
          end else begin
            p_q <= sprp_pkg::POLY_COEF[tstep_q] - prod_w[2*WB:WB];
          end
        end
        ST_MAT: begin
          unique case (op_q)
            4'd0:    ta_q   <= TW'(mf);
            4'd1:    tb_q   <= TW'(mf);
            4'd2:    m_q[0] <= mf;
            4'd3:    m_q[1] <= mf;
            4'd4:    m_q[3] <= mf;
            4'd5:    m_q[3] <= m_q[3] - mf;
            4'd6:    m_q[4] <= mf;
            4'd7:    m_q[4] <= m_q[4] + mf;
            4'd8:    m_q[5] <= mf;
            4'd9:    m_q[6] <= mf;
            4'd10:   m_q[6] <= m_q[6] + mf;
            4'd11:   m_q[7] <= mf;
            4'd12:   m_q[7] <= m_q[7] - mf;
            default: begin
              m_q[8] <= mf;
              m_q[2] <= -MW'(tv_q[2]);
            end
          endcase
        end
        ST_PNT: begin
          unique case (op_q)
            4'd0:               g0_q  <= TW'(mf);
            4'd1:               g1_q  <= TW'(mf);
            4'd2:               f0_q  <= FW'(prod_w);
            4'd3:               f1_q  <= FW'(prod_w);
            4'd4:               f2_q  <= FW'(prod_w);
            4'd5, 4'd8, 4'd11:  acc_q <= AW'(prod_w);
            4'd6, 4'd7, 4'd9,
            4'd12:              acc_q <= sum;
            4'd10:              xs_q  <= YW'(dep);
            4'd13:              ys_q  <= YW'(dep);
            default: begin
              px_q <= px_c;
              py_q <= py_c;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // ---- sequencer, config registers, output register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_TRIG;   // build the matrix from the reset angles
      mode_pnt_q  <= 1'b0;
      ph_q        <= 1'b0;
      j_q         <= '0;
      tstep_q     <= '0;
      op_q        <= '0;
      roll_q      <= A'(sprp_pkg::ROLL_RST);
      pitch_q     <= A'(sprp_pkg::PITCH_RST);
      yaw_q       <= A'(sprp_pkg::YAW_RST);
      rad_q       <= 9'(sprp_pkg::RADIUS_RST);
      cx_q        <= 10'(sprp_pkg::CX_RST);
      cy_q        <= 10'(sprp_pkg::CY_RST);
      ysc_q       <= 9'(sprp_pkg::YSCALE_RST);
      have_prev_q <= 1'b0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      out_valid_q <= 1'b0;
      from_x_q    <= '0;
      from_y_q    <= '0;
      to_x_q      <= '0;
      to_y_q      <= '0;
    end else begin
      if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_fire) begin
        unique case (sprp_pkg::cfg_reg_e'(cfg_index_i))
          sprp_pkg::REG_ROLL, sprp_pkg::REG_PITCH, sprp_pkg::REG_YAW: begin
            if (cfg_index_i == sprp_pkg::REG_ROLL)  roll_q  <= cfg_data_i[A-1:0];
            if (cfg_index_i == sprp_pkg::REG_PITCH) pitch_q <= cfg_data_i[A-1:0];
            if (cfg_index_i == sprp_pkg::REG_YAW)   yaw_q   <= cfg_data_i[A-1:0];
            // restart the matrix build
            state_q    <= ST_TRIG;
            mode_pnt_q <= 1'b0;
            ph_q       <= 1'b0;
            j_q        <= '0;
            tstep_q    <= '0;
            op_q       <= '0;
          end
          sprp_pkg::REG_RADIUS: rad_q <= cfg_data_i[8:0];
          sprp_pkg::REG_CX:     cx_q  <= cfg_data_i[9:0];
          sprp_pkg::REG_CY:     cy_q  <= cfg_data_i[9:0];
          sprp_pkg::REG_YSCALE: ysc_q <= cfg_data_i[8:0];
          default: ;
        endcase
      end else begin
        unique case (state_q)
          ST_IDLE: begin
            if (in_fire) begin
              if (s_axis_tuser) have_prev_q <= 1'b0;
              mode_pnt_q <= 1'b1;
              state_q    <= ST_TRIG;
              ph_q       <= 1'b0;
              j_q        <= '0;
              tstep_q    <= '0;
              op_q       <= '0;
            end
          end
          ST_TRIG: begin
            ph_q <= !ph_q;
            if (ph_q) begin
              if (tstep_q == TRIG_LAST) begin
                tstep_q <= '0;
                if (j_q == (mode_pnt_q ? 3'd3 : 3'd5)) begin
                  j_q     <= '0;
                  op_q    <= '0;
                  state_q <= mode_pnt_q ? ST_PNT : ST_MAT;
                end else begin
                  j_q <= j_q + 3'd1;
                end
              end else begin
                tstep_q <= tstep_q + 3'd1;
              end
            end
          end
          ST_MAT: begin
            ph_q <= !ph_q;
            if (ph_q) begin
              if (op_q == MAT_LAST) state_q <= ST_IDLE;
              else                  op_q    <= op_q + 4'd1;
            end
          end
          ST_PNT: begin
            ph_q <= !ph_q;
            if (ph_q) begin
              if (op_q == PNT_DEPTH && !visible) begin
                have_prev_q <= 1'b0;   // hidden point breaks the curve
                state_q     <= ST_IDLE;
              end else if (op_q == PNT_LAST) begin
                state_q <= ST_EMIT;
              end else begin
                op_q <= op_q + 4'd1;
              end
            end
          end
          ST_EMIT: begin
            if (!have_prev_q) begin
              have_prev_q <= 1'b1;
              prev_x_q    <= px_q;
              prev_y_q    <= py_q;
              state_q     <= ST_IDLE;
            end else if (!out_valid_q || m_axis_tready) begin
              out_valid_q <= 1'b1;
              from_x_q    <= prev_x_q;
              from_y_q    <= prev_y_q;
              to_x_q      <= px_q;
              to_y_q      <= py_q;
              prev_x_q    <= px_q;
              prev_y_q    <= py_q;
              state_q     <= ST_IDLE;
            end
          end
          default: state_q <= ST_IDLE;
        endcase
      end
    end
  end

  // ---- assertions ----
  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("segment appeared outside the emit step");

  a_angle_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_fire && (cfg_index_i == sprp_pkg::REG_ROLL || cfg_index_i == sprp_pkg::REG_PITCH ||
                  cfg_index_i == sprp_pkg::REG_YAW))
    |=> (state_q == ST_TRIG && !mode_pnt_q))
    else $error("angle write did not restart the matrix build");

  a_trig_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TRIG) |-> (tstep_q <= TRIG_LAST && j_q <= 3'd5))
    else $error("trig sequencer out of range");

  a_op_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_MAT) |-> (op_q <= MAT_LAST)) and ((state_q == ST_PNT) |-> (op_q <= PNT_LAST)))
    else $error("op counter out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(to_x_q) && $stable(to_y_q)))
    else $error("pending segment overwritten");

endmodule

### rtl/sprp_mul.sv
// sprp_mul: the one shared signed multiplier, product registered.
// Depends on nothing; operand width set by the top level.

module sprp_mul #(
  parameter int OpWidth = 33
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [OpWidth-1:0]     a_i,
  input  logic signed [OpWidth-1:0]     b_i,
  output logic signed [2*OpWidth-1:0]   p_o
);

  logic signed [2*OpWidth-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign p_o = prod_q;

endmodule
